// ===== src/cts_pkg.sv =====
// Shared types, constants and the per-byte lexer decision for the token splitter.
package cts_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WIN_DEPTH   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;
  localparam int unsigned USER_W      = 2;

  localparam logic [QUEUE_CW-1:0] QUEUE_FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

  // character codes the lexer tests for
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_HASH  = "#";
  localparam logic [BYTE_W-1:0] CH_DQ    = "\"";
  localparam logic [BYTE_W-1:0] CH_SQ    = "'";
  localparam logic [BYTE_W-1:0] CH_BSL   = "\\";
  localparam logic [BYTE_W-1:0] CH_SLASH = "/";
  localparam logic [BYTE_W-1:0] CH_GT    = ">";
  localparam logic [BYTE_W-1:0] CH_LT    = "<";
  localparam logic [BYTE_W-1:0] CH_EQ    = "=";

  typedef enum logic [4:0] {
    MODE_NORMAL    = 5'b00001,
    MODE_DIRECTIVE = 5'b00010,
    MODE_STRING    = 5'b00100,
    MODE_CHAR      = 5'b01000,
    MODE_COMMENT   = 5'b10000
  } lex_mode_e;

  typedef struct packed {
    lex_mode_e  mode;
    logic       token_open;
    logic       prior_bs;   // previous judged byte was a backslash
    logic [1:0] op_tail;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    mode:       MODE_NORMAL,
    token_open: 1'b0,
    prior_bs:   1'b0,
    op_tail:    2'd0
  };

  // One queued job: the pending bytes (lowest first), how many are valid, and the end flag.
  typedef struct packed {
    logic                           fin;
    logic [1:0]                     cnt;
    logic [WIN_DEPTH-1:0][BYTE_W-1:0] win;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    lex_state_t nxt;
    logic       emit;
    logic       start;
  } judge_t;

  function automatic logic is_ws(logic [BYTE_W-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_delim(logic [BYTE_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      ";", "(", ")", "{", "}", ",", "=", "<", ">", "+", "-", "*", "/", "%", "&",
      "|", "^", "~", "[", "]", ".", "!", "?", ":", "#": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_pair(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    return (a == "+" && (b == "+" || b == "=")) ||
           (a == "-" && (b == "-" || b == "=" || b == ">")) ||
           (a == "&" && b == "&") || (a == "|" && b == "|") ||
           (a == "=" && b == "=") || (a == "!" && b == "=") ||
           (a == ">" && (b == "=" || b == ">")) ||
           (a == "<" && (b == "=" || b == "<")) ||
           ((a == "*" || a == "/" || a == "%") && b == "=") ||
           (a == ":" && b == ":");
  endfunction

  // Decide one byte c with la bytes of lookahead (n1, n2).
  function automatic judge_t lex_judge(lex_state_t s, logic [BYTE_W-1:0] c, logic [1:0] la,
                                       logic [BYTE_W-1:0] n1, logic [BYTE_W-1:0] n2);
    judge_t            r;
    logic [BYTE_W-1:0] quote;
    r       = '{nxt: s, emit: 1'b0, start: 1'b0};
    quote   = (s.mode == MODE_STRING) ? CH_DQ : CH_SQ;
    if (s.op_tail != 2'd0) begin
      r.nxt.op_tail = s.op_tail - 2'd1;
      r.emit        = 1'b1;
    end else begin
      unique case (s.mode) inside
        MODE_DIRECTIVE: begin
          if (c == CH_NL) begin
            r.nxt.mode       = MODE_NORMAL;
            r.nxt.token_open = 1'b0;
          end else begin
            r.emit = 1'b1;
          end
        end
        MODE_STRING, MODE_CHAR: begin
          r.emit = 1'b1;
          if (c == quote && !s.prior_bs) begin
            r.nxt.mode       = MODE_NORMAL;
            r.nxt.token_open = 1'b0;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) r.nxt.mode = MODE_NORMAL;
        end
        default: begin
          r.nxt.mode = MODE_NORMAL;
          if (c == CH_HASH && !s.token_open) begin
            r.nxt.mode       = MODE_DIRECTIVE;
            r.emit           = 1'b1;
            r.start          = 1'b1;
            r.nxt.token_open = 1'b1;
          end else if (c == CH_DQ || c == CH_SQ) begin
            r.emit           = 1'b1;
            r.start          = !s.token_open;
            r.nxt.token_open = 1'b1;
            r.nxt.mode       = (c == CH_DQ) ? MODE_STRING : MODE_CHAR;
          end else if (la == 2'd2 && (c == CH_GT || c == CH_LT) && n1 == c && n2 == CH_EQ) begin
            r.emit           = 1'b1;
            r.start          = 1'b1;
            r.nxt.op_tail    = 2'd2;
            r.nxt.token_open = 1'b0;
          end else if (la != 2'd0 && is_pair(c, n1)) begin
            r.emit           = 1'b1;
            r.start          = 1'b1;
            r.nxt.op_tail    = 2'd1;
            r.nxt.token_open = 1'b0;
          end else if (c == CH_SLASH && la != 2'd0 && n1 == CH_SLASH) begin
            r.nxt.mode       = MODE_COMMENT;
            r.nxt.token_open = 1'b0;
          end else if (is_ws(c)) begin
            r.nxt.token_open = 1'b0;
          end else if (is_delim(c)) begin
            r.emit           = 1'b1;
            r.start          = 1'b1;
            r.nxt.token_open = 1'b0;
          end else begin
            r.emit           = 1'b1;
            r.start          = !s.token_open;
            r.nxt.token_open = 1'b1;
          end
        end
      endcase
    end
    r.nxt.prior_bs = (c == CH_BSL);
    return r;
  endfunction

endpackage

// ===== src/cts_front.sv =====
// Input side: keeps the two-byte lookahead window and queues bytes that are ready to judge.
module cts_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [cts_pkg::BYTE_W-1:0] s_axis_tdata_i,  // source_byte
  input  logic                      s_axis_tlast_i,  // final_byte
  input  cts_pkg::queue_status_t    queue_status_i,
  output logic                      job_valid_o,
  output cts_pkg::job_t             job_o
);
  import cts_pkg::*;

  logic [1:0][BYTE_W-1:0] win_q, win_d;
  logic [1:0]             fill_q, fill_d;
  logic                   accept;

  assign s_axis_tready_o = !queue_status_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign job_valid_o     = accept && (fill_q == 2'd2 || s_axis_tlast_i);

  always_comb begin
    job_o.win    = '0;
    job_o.fin    = s_axis_tlast_i;
    job_o.cnt    = fill_q + 2'd1;
    case (fill_q)
      2'd2: begin
        job_o.win[0] = win_q[0];
        job_o.win[1] = win_q[1];
        job_o.win[2] = s_axis_tdata_i;
      end
      2'd1: begin
        job_o.win[0] = win_q[0];
        job_o.win[1] = s_axis_tdata_i;
      end
      default: begin
        job_o.win[0] = s_axis_tdata_i;
      end
    endcase
  end

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        win_d  = '0;
        fill_d = 2'd0;
      end else if (fill_q == 2'd2) begin
        win_d[0] = win_q[1];
        win_d[1] = s_axis_tdata_i;
      end else begin
        win_d[fill_q[0]] = s_axis_tdata_i;
        fill_d           = fill_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= 2'd0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== src/cts_queue.sv =====
// Short register queue of judge jobs between the front and the back.
module cts_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cts_pkg::job_t          push_data_i,
  input  logic                   pop_i,
  output cts_pkg::job_t          head_o,
  output cts_pkg::queue_status_t status_o
);
  import cts_pkg::*;

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == QUEUE_FULL_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QUEUE_CW'(1);
      2'b01:   cnt_d = cnt_q - QUEUE_CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/cts_back.sv =====
// Output side: judges one pending byte per cycle while the output is not stalled, closes the source with an end marker.
module cts_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cts_pkg::job_t              head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [cts_pkg::BYTE_W-1:0] m_axis_tdata_o,  // token_byte
  output logic [cts_pkg::USER_W-1:0] m_axis_tuser_o,  // [0] starts_token, [1] end_marker
  output logic                       m_axis_tlast_o   // last_of_run
);
  import cts_pkg::*;

  job_t              cur_q, cur_d;
  logic              cur_valid_q, cur_valid_d;
  lex_state_t        lex_q, lex_d;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [USER_W-1:0] out_user_q;
  logic              out_last_q;

  judge_t            jr;
  logic              advance, step, at_end, done, load, step_emit;

  assign advance = !out_valid_q || m_axis_tready_i;
  assign step    = advance && cur_valid_q;
  // all pending bytes judged: the end marker beat is due
  assign at_end  = (cur_q.cnt == 2'd0);
  assign done    = step && (at_end || !cur_q.fin);
  assign load    = head_valid_i && (!cur_valid_q || done);
  assign pop_o   = load;

  assign jr        = lex_judge(lex_q, cur_q.win[0], cur_q.cnt - 2'd1, cur_q.win[1], cur_q.win[2]);
  assign step_emit = at_end || jr.emit;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    if (load) begin
      cur_d       = head_i;
      cur_valid_d = 1'b1;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end else if (step) begin
      cur_d.win[0] = cur_q.win[1];
      cur_d.win[1] = cur_q.win[2];
      cur_d.cnt    = cur_q.cnt - 2'd1;
    end
  end

  always_comb begin
    lex_d = lex_q;
    if (step) lex_d = at_end ? LEX_RESET : jr.nxt;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= at_end ? '0 : cur_q.win[0];
      out_user_q <= {at_end, !at_end && jr.start};
      out_last_q <= at_end || !cur_q.fin;
    end
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      lex_q       <= LEX_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      lex_q       <= lex_d;
      if (advance) out_valid_q <= step && step_emit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== src/c_source_token_splitter.sv =====
// Top level of the C source token splitter: front window, job queue, lexer back end.
// Path: a byte is judged once two later bytes arrive; its beat then passes the queue, the job and output registers.
// Throughput: one byte per cycle while the queue is not full; a tlast byte has the back end
//   judge each pending byte, then the end marker; nonstop sources stall once the queue fills.
// Reset: asynchronous, active low; window, queue and lexer mode clear at once, no sweep.
// After a tlast byte the lexer returns to its reset state.
module c_source_token_splitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [cts_pkg::BYTE_W-1:0] s_axis_tdata_i,  // source_byte
  input  logic                       s_axis_tlast_i,  // final_byte
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [cts_pkg::BYTE_W-1:0] m_axis_tdata_o,  // token_byte
  output logic [cts_pkg::USER_W-1:0] m_axis_tuser_o,  // [0] starts_token, [1] end_marker
  output logic                       m_axis_tlast_o   // last_of_run
);
  import cts_pkg::*;

  job_t          push_job, head_job;
  logic          push_valid, pop;
  queue_status_t q_status;

  cts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .queue_status_i  (q_status),
    .job_valid_o     (push_valid),
    .job_o           (push_job)
  );

  cts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .status_o    (q_status)
  );

  cts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_job),
    .head_valid_i    (!q_status.empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // end marker beat is zero data, no token start, and closes the run
  a_end_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      (m_axis_tlast_o && m_axis_tdata_o == '0 && !m_axis_tuser_o[0]))
    else $error("end marker beat malformed");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_valid && q_status.full))
    else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("job popped from empty queue");

  // a tlast byte always queues a job
  a_last_queues_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |-> push_valid)
    else $error("final beat produced no job");

endmodule
